[rtl/core/bwrc_pkg.sv]
// ----------------------------------------------------------------------------
// bwrc_pkg
// Shared types, constants and the modular add used by the walk counter.
// ----------------------------------------------------------------------------
package bwrc_pkg;

  localparam int unsigned ROW_DEPTH = 1024;
  localparam int unsigned POS_W     = $clog2(ROW_DEPTH);
  localparam int unsigned STEP_W    = 10;
  localparam int unsigned LEN_W     = 20;
  localparam int unsigned WAY_W     = 30;
  localparam int unsigned SUM_W     = 32;

  localparam logic [SUM_W-1:0] WAY_MODULUS   = SUM_W'(1000000007);
  localparam logic [SUM_W-1:0] WAY_MODULUS_2 = SUM_W'(2000000014);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PRIME,
    ST_LOAD,
    ST_SWEEP,
    ST_FETCH,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] waddr;
    logic [WAY_W-1:0] wdata;
    logic [POS_W-1:0] raddr;
  } ram_req_t;

  // Adds three residues and reduces the sum, which stays below three moduli.
  function automatic logic [WAY_W-1:0] mod_add3(input logic [WAY_W-1:0] a,
                                                input logic [WAY_W-1:0] b,
                                                input logic [WAY_W-1:0] c);
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] r;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    if (s >= WAY_MODULUS_2) begin
      r = s - WAY_MODULUS_2;
    end else if (s >= WAY_MODULUS) begin
      r = s - WAY_MODULUS;
    end else begin
      r = s;
    end
    return r[WAY_W-1:0];
  endfunction

endpackage

[rtl/core/bwrc_row_ram.sv]
// ----------------------------------------------------------------------------
// bwrc_row_ram
// Row store of per-position counts: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bwrc_row_ram
  import bwrc_pkg::*;
(
  input  logic             clk,
  input  ram_req_t         req,
  output logic [WAY_W-1:0] rdata
);

  logic [WAY_W-1:0] mem [ROW_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[rtl/core/bounded_walk_return_counter.sv]
// ----------------------------------------------------------------------------
// bounded_walk_return_counter
// Counts walks of step_count moves that start and end at position 0.
// ----------------------------------------------------------------------------
// Usage: an input word (step_count, array_length) is taken when in_valid is
// high and in_stall is low. in_stall stays high while a word is in work.
// Each input word yields one output word, way_count, offered on out_valid
// and taken when out_stall is low. The result register holds a finished
// word while the next input word is already in work.
// Sequence, with L = min(step_count, array_length - 1): the sequencer clears
// positions 0 to L of the row, each step primes the read pipeline and then
// sweeps positions 0 to L, and a last fetch reads position 0 and loads the
// result. The pace is set by the single read port of the row memory, which
// visits one position per cycle.
// Reset returns the sequencer to idle and drops out_valid; the row memory
// is not cleared, since every item rewrites the positions whose values it uses.
// When the receiver stalls, the finished word waits in the result register
// and the sequencer holds its last cycle until that register is free.
// ----------------------------------------------------------------------------
module bounded_walk_return_counter
  import bwrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [STEP_W-1:0] step_count,
  input  logic [LEN_W-1:0]  array_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WAY_W-1:0]  way_count
);

  st_t              state;
  st_t              state_next;
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] step_index;
  logic [POS_W-1:0]  position_index;
  logic [POS_W-1:0]  last_position;
  logic [WAY_W-1:0]  left_neighbor_old;
  logic [WAY_W-1:0]  here_old;
  logic [WAY_W-1:0]  rdata;
  logic [WAY_W-1:0]  right_old;
  logic [LEN_W-1:0]  length_m1;
  logic [POS_W-1:0]  limit;
  logic              in_take;
  logic              at_last;
  logic              out_free;
  ram_req_t          req;

  bwrc_row_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign at_last  = (position_index == last_position);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    length_m1 = (array_length == '0) ? '0 : array_length - LEN_W'(1);
    if (length_m1 > LEN_W'(step_count)) begin
      limit = POS_W'(step_count);
    end else begin
      limit = length_m1[POS_W-1:0];
    end
  end

  assign right_old = at_last ? '0 : rdata;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        if (at_last) begin
          state_next = (steps == '0) ? ST_FETCH : ST_PRIME;
        end
      end
      ST_PRIME: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (at_last) begin
          state_next = (step_index == steps) ? ST_FETCH : ST_PRIME;
        end
      end
      ST_FETCH: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.we    = 1'b0;
    req.waddr = position_index;
    req.wdata = '0;
    req.raddr = '0;
    case (state)
      ST_INIT: begin
        req.we    = 1'b1;
        req.wdata = (position_index == '0) ? WAY_W'(1) : '0;
      end
      ST_LOAD: begin
        req.raddr = POS_W'(1);
      end
      ST_SWEEP: begin
        req.we    = 1'b1;
        req.wdata = mod_add3(here_old, left_neighbor_old, right_old);
        req.raddr = position_index + POS_W'(2);
      end
      default: begin
        req.raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps             <= '0;
      step_index        <= '0;
      position_index    <= '0;
      last_position     <= '0;
      left_neighbor_old <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            steps          <= step_count;
            last_position  <= limit;
            position_index <= '0;
            step_index     <= '0;
          end
        end
        ST_INIT: begin
          if (at_last) begin
            position_index <= '0;
            step_index     <= STEP_W'(1);
          end else begin
            position_index <= position_index + POS_W'(1);
          end
        end
        ST_LOAD: begin
          left_neighbor_old <= '0;
          here_old          <= rdata;
        end
        ST_SWEEP: begin
          left_neighbor_old <= here_old;
          here_old          <= rdata;
          if (at_last) begin
            position_index <= '0;
            if (step_index != steps) begin
              step_index <= step_index + STEP_W'(1);
            end
          end else begin
            position_index <= position_index + POS_W'(1);
          end
        end
        default: begin
          position_index <= position_index;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
      way_count <= rdata;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_take_starts_init: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_INIT)
    else $error("Accepted word did not start the row clear.");

  a_position_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP || state == ST_INIT) |-> position_index <= last_position)
    else $error("Sweep position ran past the last position.");

  a_write_is_residue: assert property (@(posedge clk) disable iff (rst)
    req.we |-> SUM_W'(req.wdata) < WAY_MODULUS)
    else $error("Row write is not reduced below the modulus.");

  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (step_index <= steps && step_index != '0))
    else $error("Step counter is outside the requested step range.");
`endif

endmodule
